@@ src/dfrd_pkg.sv @@
package dfrd_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_BYTES = 65536;
  localparam int ADDR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  // Field widths
  localparam int PIXEL_W = 8;
  localparam int LEN_W   = 17;
  localparam int FRAME_W = 24;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W   = 3 * FRAME_W;

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUP_MIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES    = 1'b1;

  // Register reset values
  localparam logic [FRAME_W-1:0] DUP_MIN_LENGTH_RST = FRAME_W'(2);
  localparam logic [LEN_W-1:0]   FRAME_BYTES_RST    = LEN_W'(65536);

  // Frame event queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // One finished frame as seen by the run tracker
  typedef struct packed {
    logic differs;
    logic last;
  } frame_event_t;

  // Index of the last byte of a frame for a given length register
  function automatic logic [ADDR_W-1:0] last_byte_pos(input logic [LEN_W-1:0] fb);
    logic [LEN_W-1:0] fb_m1;
    fb_m1 = fb - LEN_W'(1);
    if (fb == '0) begin
      last_byte_pos = '0;
    end else if (32'(fb) > 32'(MAX_FRAME_BYTES)) begin
      last_byte_pos = ADDR_W'(MAX_FRAME_BYTES - 1);
    end else begin
      last_byte_pos = ADDR_W'(fb_m1);
    end
  endfunction

endpackage

@@ src/dfrd_ram.sv @@
module dfrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/dfrd_front.sv @@
module dfrd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dfrd_pkg::LEN_W-1:0]         frame_bytes,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dfrd_pkg::PIXEL_W-1:0]       s_tdata,
  input  logic                               s_tlast,
  input  logic [dfrd_pkg::QUEUE_CNT_W-1:0]   queue_level,
  output logic                               evt_push,
  output dfrd_pkg::frame_event_t             evt_data
);

  logic                              accept;
  logic [dfrd_pkg::ADDR_W-1:0]       byte_index;
  logic [dfrd_pkg::ADDR_W-1:0]       last_pos;
  logic                              frame_end;

  // Compare stage
  logic                              b_valid;
  logic [dfrd_pkg::PIXEL_W-1:0]      b_px;
  logic [dfrd_pkg::ADDR_W-1:0]       b_pos;
  logic                              b_end;
  logic                              b_last;
  logic                              b_byp;
  logic [dfrd_pkg::PIXEL_W-1:0]      b_byp_data;
  logic [dfrd_pkg::PIXEL_W-1:0]      rd_data;
  logic [dfrd_pkg::PIXEL_W-1:0]      old_px;
  logic                              frame_differs;
  logic                              differs_next;

  // Leave room in the queue for the byte still in the compare stage
  assign s_tready = queue_level <= dfrd_pkg::QUEUE_CNT_W'(dfrd_pkg::QUEUE_DEPTH - 2);
  assign accept   = s_tvalid && s_tready;

  assign last_pos  = dfrd_pkg::last_byte_pos(frame_bytes);
  assign frame_end = s_tlast || (byte_index >= last_pos);

  // Advance the byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      byte_index <= frame_end ? '0 : byte_index + dfrd_pkg::ADDR_W'(1);
    end
  end

  dfrd_ram #(
    .WIDTH (dfrd_pkg::PIXEL_W),
    .DEPTH (dfrd_pkg::MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_pos),
    .wdata (b_px),
    .re    (accept),
    .raddr (byte_index),
    .rdata (rd_data)
  );

  // Load the compare stage; forward a write to the same entry in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
    if (accept) begin
      b_px       <= s_tdata;
      b_pos      <= byte_index;
      b_end      <= frame_end;
      b_last     <= s_tlast;
      b_byp      <= b_valid && (b_pos == byte_index);
      b_byp_data <= b_px;
    end
  end

  assign old_px       = b_byp ? b_byp_data : rd_data;
  assign differs_next = frame_differs || (old_px != b_px);

  // Accumulate the per-frame difference flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_differs <= 1'b0;
    end else if (b_valid) begin
      frame_differs <= b_end ? 1'b0 : differs_next;
    end
  end

  // Emit one event per finished frame
  assign evt_push         = b_valid && b_end;
  assign evt_data.differs = differs_next;
  assign evt_data.last    = b_last;

endmodule

@@ src/dfrd_fifo.sv @@
module dfrd_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  dfrd_pkg::frame_event_t           push_data,
  output logic                             pop_valid,
  input  logic                             pop_ready,
  output dfrd_pkg::frame_event_t           pop_data,
  output logic [dfrd_pkg::QUEUE_CNT_W-1:0] level
);

  dfrd_pkg::frame_event_t             entries [dfrd_pkg::QUEUE_DEPTH];
  logic [dfrd_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [dfrd_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [dfrd_pkg::QUEUE_CNT_W-1:0]   count;
  logic                               pop;

  assign pop_valid = count != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];
  assign level     = count;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dfrd_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dfrd_pkg::QUEUE_PTR_W'(1);
      end
      count <= count + dfrd_pkg::QUEUE_CNT_W'(push) - dfrd_pkg::QUEUE_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < dfrd_pkg::QUEUE_CNT_W'(dfrd_pkg::QUEUE_DEPTH)) || pop)
    else $error("frame event queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dfrd_pkg::QUEUE_CNT_W'(dfrd_pkg::QUEUE_DEPTH))
    else $error("frame event queue count out of range");

endmodule

@@ src/dfrd_back.sv @@
module dfrd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dfrd_pkg::FRAME_W-1:0]       dup_min_length,
  input  logic                               evt_valid,
  output logic                               evt_ready,
  input  dfrd_pkg::frame_event_t             evt_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dfrd_pkg::OUT_W-1:0]         m_tdata
);

  logic [dfrd_pkg::FRAME_W-1:0] frame_index;
  logic                         run_active;
  logic [dfrd_pkg::FRAME_W-1:0] run_start;
  logic [dfrd_pkg::FRAME_W-1:0] reported_count;

  logic                         pop;
  logic                         has_prev;
  logic                         open_now;
  logic                         close_diff;
  logic                         close_last;
  logic [dfrd_pkg::FRAME_W-1:0] prev_index;
  logic [dfrd_pkg::FRAME_W-1:0] start_eff;
  logic [dfrd_pkg::FRAME_W-1:0] end_sel;
  logic [dfrd_pkg::FRAME_W-1:0] run_len;
  logic                         report;
  logic [dfrd_pkg::FRAME_W-1:0] count_next;

  // Take an event whenever the result register is free or draining
  assign evt_ready = !m_tvalid || m_tready;
  assign pop       = evt_valid && evt_ready;

  // Classify the finished frame against the open run
  assign has_prev   = frame_index != '0;
  assign prev_index = frame_index - dfrd_pkg::FRAME_W'(1);
  assign open_now   = has_prev && !evt_data.differs && !run_active;
  assign close_diff = has_prev && evt_data.differs && run_active;
  assign close_last = evt_data.last && (run_active || open_now) && !close_diff;
  assign start_eff  = open_now ? prev_index : run_start;
  assign end_sel    = close_diff ? prev_index : frame_index;
  assign run_len    = end_sel - start_eff;
  assign report     = (close_diff || close_last) && (run_len >= dup_min_length);
  assign count_next = (reported_count == dfrd_pkg::FRAME_MAX) ? reported_count
                    : reported_count + dfrd_pkg::FRAME_W'(1);

  // Update run state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index    <= '0;
      run_active     <= 1'b0;
      run_start      <= '0;
      reported_count <= '0;
    end else if (pop) begin
      if (report) begin
        reported_count <= count_next;
      end
      if (evt_data.last) begin
        frame_index <= '0;
        run_active  <= 1'b0;
        run_start   <= '0;
      end else begin
        if (frame_index != dfrd_pkg::FRAME_MAX) begin
          frame_index <= frame_index + dfrd_pkg::FRAME_W'(1);
        end
        run_active <= open_now || (run_active && !close_diff);
        run_start  <= start_eff;
      end
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (evt_ready) begin
      m_tvalid <= pop && report;
    end
    if (pop && report) begin
      m_tdata <= {count_next, end_sel, start_eff};
    end
  end

  a_start_before_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[dfrd_pkg::FRAME_W-1:0]
                  <= m_tdata[2*dfrd_pkg::FRAME_W-1:dfrd_pkg::FRAME_W]))
    else $error("reported run starts after it ends");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[dfrd_pkg::OUT_W-1:2*dfrd_pkg::FRAME_W] != '0))
    else $error("reported interval count is zero");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (pop && report) |=> (reported_count != '0))
    else $error("interval count did not advance on report");

endmodule

@@ src/duplicate_frame_run_detector_unit.sv @@
// Path: compare stage registers, then frame event queue, then m_tdata result register.
// Throughput: one byte per cycle while s_tready is high, set by one read and one write of
// the frame store per byte. s_tready drops only when the frame event queue backs up behind
// a stalled result sink. Reset (rst, synchronous): clears positions, frame and run state,
// counts and valid flags, and loads the configuration registers with their reset values;
// frame store contents stay undefined until written, with no clearing pass.
module duplicate_frame_run_detector_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dfrd_pkg::PIXEL_W-1:0]        s_tdata,   // pixel_byte
  input  logic                                s_tlast,   // stream_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dfrd_pkg::OUT_W-1:0]          m_tdata,   // run_start_frame, run_end_frame,
                                                          // interval_count
  input  logic                                cfg_we,
  input  logic [dfrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dfrd_pkg::CFG_W-1:0]          cfg_data
);

  logic [dfrd_pkg::FRAME_W-1:0]     dup_min_length;
  logic [dfrd_pkg::LEN_W-1:0]       frame_bytes;
  logic                             evt_push;
  dfrd_pkg::frame_event_t           evt_in;
  logic                             evt_valid;
  logic                             evt_ready;
  dfrd_pkg::frame_event_t           evt_out;
  logic [dfrd_pkg::QUEUE_CNT_W-1:0] queue_level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_min_length <= dfrd_pkg::DUP_MIN_LENGTH_RST;
      frame_bytes    <= dfrd_pkg::FRAME_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfrd_pkg::REG_DUP_MIN_LENGTH: dup_min_length <= cfg_data[dfrd_pkg::FRAME_W-1:0];
        dfrd_pkg::REG_FRAME_BYTES:    frame_bytes    <= cfg_data[dfrd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  dfrd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .queue_level (queue_level),
    .evt_push    (evt_push),
    .evt_data    (evt_in)
  );

  dfrd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_push),
    .push_data (evt_in),
    .pop_valid (evt_valid),
    .pop_ready (evt_ready),
    .pop_data  (evt_out),
    .level     (queue_level)
  );

  dfrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .dup_min_length (dup_min_length),
    .evt_valid      (evt_valid),
    .evt_ready      (evt_ready),
    .evt_data       (evt_out),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule
